@@ rtl/pwce_pkg.sv @@
// Package for the pulse width capture extender: widths, operation and register
// codes, payload structs and the overflow-checked arithmetic helpers.
// No dependencies.
package pwce_pkg;

    localparam int TIMER_WIDTH  = 16;
    localparam int RESULT_WIDTH = 32;

    // fixed widths of the channel fields
    localparam int WIDTH_W = 16;
    localparam int OUT_W   = 32;
    localparam int OP_W    = 2;
    localparam int CHAN_W  = 2;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_SELECT    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INVERTED_POLARITY = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONTINUOUS_MODE   = 2'd2;

    // operation codes
    localparam logic [OP_W-1:0] OP_START    = 2'd0;
    localparam logic [OP_W-1:0] OP_STOP     = 2'd1;
    localparam logic [OP_W-1:0] OP_OVERFLOW = 2'd2;
    localparam logic [OP_W-1:0] OP_READY    = 2'd3;

    localparam logic [63:0] RMASK64 = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - RESULT_WIDTH);
    localparam logic [63:0] TMAX64  = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - TIMER_WIDTH);
    // largest count whose product with the timer maximum still fits
    localparam logic [RESULT_WIDTH-1:0] MUL_LIMIT = RESULT_WIDTH'(RMASK64 / TMAX64);
    localparam logic [RESULT_WIDTH-1:0] COUNT_MAX = RESULT_WIDTH'(RMASK64);

    typedef logic [RESULT_WIDTH-1:0] count_t;

    typedef struct packed {
        logic [CHAN_W-1:0] channel_select;
        logic              inverted_polarity;
        logic              continuous_mode;
    } cfg_t;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic               level_high;
        logic [WIDTH_W-1:0] positive_width;
        logic [WIDTH_W-1:0] negative_width;
    } item_t;

    typedef struct packed {
        logic [OUT_W-1:0]  period_ticks;
        logic [OUT_W-1:0]  pulse_ticks;
        logic              status;
        logic [CHAN_W-1:0] channel;
        logic              still_running;
    } result_t;

    // multiply by 2^TIMER_WIDTH - 1 as shift and subtract; top bit flags overflow
    function automatic logic [RESULT_WIDTH:0] mul_tmax(input count_t a);
        logic [RESULT_WIDTH+TIMER_WIDTH-1:0] wide;
        logic [RESULT_WIDTH+TIMER_WIDTH-1:0] prod;
        wide = {{TIMER_WIDTH{1'b0}}, a};
        prod = (wide << TIMER_WIDTH) - wide;
        return {(a > MUL_LIMIT), prod[RESULT_WIDTH-1:0]};
    endfunction

    // add with carry out as overflow flag
    function automatic logic [RESULT_WIDTH:0] add_chk(input count_t a, input count_t b);
        return {1'b0, a} + {1'b0, b};
    endfunction

endpackage

@@ rtl/pwce_in_if.sv @@
// Input channel of the pulse width capture extender: valid/ready plus item fields.
// Depends on pwce_pkg.
interface pwce_in_if
    import pwce_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic               level_high;
    logic [WIDTH_W-1:0] positive_width;
    logic [WIDTH_W-1:0] negative_width;

    modport source (output valid, output operation, output level_high,
                    output positive_width, output negative_width, input ready);
    modport sink   (input valid, input operation, input level_high,
                    input positive_width, input negative_width, output ready);
endinterface

@@ rtl/pwce_out_if.sv @@
// Result channel of the pulse width capture extender: valid/ready plus result fields.
// Depends on pwce_pkg.
interface pwce_out_if
    import pwce_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [OUT_W-1:0]  period_ticks;
    logic [OUT_W-1:0]  pulse_ticks;
    logic              status;
    logic [CHAN_W-1:0] channel;
    logic              still_running;

    modport source (output valid, output period_ticks, output pulse_ticks,
                    output status, output channel, output still_running, input ready);
    modport sink   (input valid, input period_ticks, input pulse_ticks,
                    input status, input channel, input still_running, output ready);
endinterface

@@ rtl/pulse_width_capture_extender.sv @@
// Top level of the pulse width capture extender.
// Depends on pwce_pkg, pwce_in_if, pwce_out_if, pwce_cfg and pwce_engine.
//
// Turns events from a 16-bit pulse-width timer into 32-bit period and pulse
// results. Each input transaction is start, stop, counter overflow (with the
// input level) or widths ready; only widths ready while a capture runs gives
// a result transaction. An accepted transaction is held in an input register
// and processed against the overflow counts by a single pass of
// constant-multiply and add logic, and the result lands in an output
// register. One transaction is taken every clock cycle while the result
// side keeps up; a result becomes visible once it has passed through the
// input register and then the output register.
// The output register decouples the sides: a waiting result stalls intake
// only once both registers are full. Configuration writes are ignored while
// a capture runs and should be made only when no transaction is in flight.
module pulse_width_capture_extender
    import pwce_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    pwce_in_if.sink                item,
    pwce_out_if.source             result,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t    cfg;
    logic    capture_active;

    item_t   stage_item_reg;
    logic    stage_valid_reg, stage_valid_next;
    result_t out_reg;
    logic    out_valid_reg, out_valid_next;

    logic    fire;
    logic    has_result;
    result_t calc_result;
    logic    take;

    // advance the held transaction when the output slot is free or emptying
    assign fire = stage_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !stage_valid_reg || fire;
    assign take = item.valid && item.ready;

    pwce_cfg u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .capture_active (capture_active),
        .cfg            (cfg)
    );

    pwce_engine u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire),
        .item           (stage_item_reg),
        .cfg            (cfg),
        .has_result     (has_result),
        .result         (calc_result),
        .capture_active (capture_active)
    );

    always_comb
    begin
        stage_valid_next = take || (stage_valid_reg && !fire);
        // hold an untaken result, load a fresh one when the engine gives it
        out_valid_next   = (fire && has_result) || (out_valid_reg && !result.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_item_reg.operation      <= item.operation;
            stage_item_reg.level_high     <= item.level_high;
            stage_item_reg.positive_width <= item.positive_width;
            stage_item_reg.negative_width <= item.negative_width;
        end
        if (fire && has_result)
        begin
            out_reg <= calc_result;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.period_ticks  = out_reg.period_ticks;
    assign result.pulse_ticks   = out_reg.pulse_ticks;
    assign result.status        = out_reg.status;
    assign result.channel       = out_reg.channel;
    assign result.still_running = out_reg.still_running;

endmodule

@@ rtl/pwce_cfg.sv @@
// Configuration registers of the pulse width capture extender.
// Depends on pwce_pkg.
module pwce_cfg
    import pwce_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   capture_active,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        // drop writes while a capture runs
        if (cfg_wr_en && !capture_active)
        begin
            unique case (cfg_index)
                CFG_CHANNEL_SELECT:    cfg_next.channel_select    = cfg_data[CHAN_W-1:0];
                CFG_INVERTED_POLARITY: cfg_next.inverted_polarity = cfg_data[0];
                CFG_CONTINUOUS_MODE:   cfg_next.continuous_mode   = cfg_data[0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/pwce_engine.sv @@
// Capture state and result calculation of the pulse width capture extender.
// Depends on pwce_pkg.
module pwce_engine
    import pwce_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  item_t   item,
    input  cfg_t    cfg,
    output logic    has_result,
    output result_t result,
    output logic    capture_active
);

    count_t hi_count_reg, hi_count_next;
    count_t lo_count_reg, lo_count_next;
    logic   wrapped_reg, wrapped_next;
    logic   active_reg, active_next;

    count_t              ppw;
    count_t              npw;
    count_t              sel_count;
    count_t              sel_width;
    logic [RESULT_WIDTH:0] pulse_mul, pulse_sum;
    logic [RESULT_WIDTH:0] cnt_sum, period_mul, period_add1, period_add2;
    logic                pulse_err;
    logic                period_err;

    always_comb
    begin
        ppw = RESULT_WIDTH'(item.positive_width[TIMER_WIDTH-1:0]);
        npw = RESULT_WIDTH'(item.negative_width[TIMER_WIDTH-1:0]);
        sel_count = cfg.inverted_polarity ? lo_count_reg : hi_count_reg;
        sel_width = cfg.inverted_polarity ? npw : ppw;

        pulse_mul = mul_tmax(sel_count);
        pulse_sum = add_chk(pulse_mul[RESULT_WIDTH-1:0], sel_width);
        pulse_err = pulse_mul[RESULT_WIDTH] | pulse_sum[RESULT_WIDTH];

        cnt_sum     = add_chk(hi_count_reg, lo_count_reg);
        period_mul  = mul_tmax(cnt_sum[RESULT_WIDTH-1:0]);
        period_add1 = add_chk(period_mul[RESULT_WIDTH-1:0], ppw);
        period_add2 = add_chk(period_add1[RESULT_WIDTH-1:0], npw);
        period_err  = cnt_sum[RESULT_WIDTH] | period_mul[RESULT_WIDTH]
                    | period_add1[RESULT_WIDTH] | period_add2[RESULT_WIDTH];
    end

    always_comb
    begin
        hi_count_next = hi_count_reg;
        lo_count_next = lo_count_reg;
        wrapped_next  = wrapped_reg;
        active_next   = active_reg;
        has_result    = 1'b0;
        unique case (item.operation)
            OP_START:
            begin
                if (!active_reg)
                begin
                    hi_count_next = '0;
                    lo_count_next = '0;
                    wrapped_next  = 1'b0;
                    active_next   = 1'b1;
                end
            end
            OP_STOP:
            begin
                active_next = 1'b0;
            end
            OP_OVERFLOW:
            begin
                if (active_reg)
                begin
                    if (item.level_high)
                    begin
                        hi_count_next = hi_count_reg + count_t'(1);
                        if (hi_count_reg == COUNT_MAX)
                        begin
                            wrapped_next = 1'b1;
                        end
                    end
                    else
                    begin
                        lo_count_next = lo_count_reg + count_t'(1);
                        if (lo_count_reg == COUNT_MAX)
                        begin
                            wrapped_next = 1'b1;
                        end
                    end
                end
            end
            OP_READY:
            begin
                if (active_reg)
                begin
                    has_result    = 1'b1;
                    hi_count_next = '0;
                    lo_count_next = '0;
                    wrapped_next  = 1'b0;
                    if (!cfg.continuous_mode)
                    begin
                        active_next = 1'b0;
                    end
                end
            end
            default:
            begin
                active_next = active_reg;
            end
        endcase

        result.pulse_ticks   = pulse_err ? '0 : OUT_W'(pulse_sum[RESULT_WIDTH-1:0]);
        result.period_ticks  = (pulse_err | period_err)
                             ? '0 : OUT_W'(period_add2[RESULT_WIDTH-1:0]);
        result.status        = pulse_err | period_err | wrapped_reg;
        result.channel       = cfg.channel_select;
        result.still_running = active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hi_count_reg <= '0;
            lo_count_reg <= '0;
            wrapped_reg  <= 1'b0;
            active_reg   <= 1'b0;
        end
        else if (fire)
        begin
            hi_count_reg <= hi_count_next;
            lo_count_reg <= lo_count_next;
            wrapped_reg  <= wrapped_next;
            active_reg   <= active_next;
        end
    end

    assign capture_active = active_reg;

endmodule

@@ dv/pwce_capture_checker_pkg.sv @@
`timescale 1ns / 100ps
// Scoreboard class for the pulse width capture extender test: predicts the
// extended period and pulse results and checks the result channel.
// Depends on pwce_pkg.
package pwce_capture_checker_pkg;
    import pwce_pkg::*;

    typedef bit [63:0] wide_t;

    localparam wide_t TICK_MAX = (64'd1 << TIMER_WIDTH) - 64'd1;
    localparam wide_t SPAN_MAX = (64'd1 << RESULT_WIDTH) - 64'd1;

    class capture_checker;
        int unsigned       failures;
        result_t           awaited_results[$];
        logic [CHAN_W-1:0] chan_sel;
        bit                inv_pol;
        bit                cont_mode;
        wide_t             high_ovf;
        wide_t             low_ovf;
        bit                wrapped;
        bit                running;

        function new();
            failures  = 0;
            chan_sel  = '0;
            inv_pol   = 1'b0;
            cont_mode = 1'b0;
            running   = 1'b0;
            clear_counts();
        endfunction

        function void clear_counts();
            high_ovf = '0;
            low_ovf  = '0;
            wrapped  = 1'b0;
        endfunction

        function bit capture_running();
            return running;
        endfunction

        function int outstanding();
            return awaited_results.size();
        endfunction

        // writes are dropped while a capture runs
        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (running)
                return;
            case (idx)
                CFG_CHANNEL_SELECT:    chan_sel  = data[CHAN_W-1:0];
                CFG_INVERTED_POLARITY: inv_pol   = data[0];
                CFG_CONTINUOUS_MODE:   cont_mode = data[0];
                default: ;
            endcase
        endfunction

        // count times the timer maximum; returns 1 when it leaves the result range
        function bit scale_ticks(input wide_t a, output wide_t r);
            r = a * TICK_MAX;
            return (a != 0) && (a > SPAN_MAX / TICK_MAX);
        endfunction

        function bit sum_spans(input wide_t a, input wide_t b, output wide_t r);
            r = a + b;
            return a > SPAN_MAX - b;
        endfunction

        // advance the prediction by one accepted transaction; 0 if it was ignored
        function bit note_item(item_t it);
            wide_t   ppw;
            wide_t   npw;
            wide_t   t;
            wide_t   period;
            wide_t   pulse;
            bit      over;
            result_t want;

            ppw    = wide_t'(it.positive_width) & TICK_MAX;
            npw    = wide_t'(it.negative_width) & TICK_MAX;
            period = '0;
            pulse  = '0;
            case (it.operation)
                OP_START:
                begin
                    if (running)
                        return 1'b0;
                    clear_counts();
                    running = 1'b1;
                    return 1'b1;
                end
                OP_STOP:
                begin
                    running = 1'b0;
                    return 1'b1;
                end
                default: ;
            endcase
            if (!running)
                return 1'b0;
            if (it.operation == OP_OVERFLOW)
            begin
                if (it.level_high)
                begin
                    if (high_ovf >= SPAN_MAX)
                        wrapped = 1'b1;
                    high_ovf = (high_ovf + 1) & SPAN_MAX;
                end
                else
                begin
                    if (low_ovf >= SPAN_MAX)
                        wrapped = 1'b1;
                    low_ovf = (low_ovf + 1) & SPAN_MAX;
                end
                return 1'b1;
            end

            // widths ready: pulse first, period only if the pulse fitted
            over = scale_ticks(inv_pol ? low_ovf : high_ovf, t);
            if (!over)
                over = sum_spans(t, inv_pol ? npw : ppw, t);
            if (!over)
            begin
                pulse = t;
                over = sum_spans(high_ovf, low_ovf, t);
                if (!over)
                    over = scale_ticks(t, t);
                if (!over)
                    over = sum_spans(t, ppw, t);
                if (!over)
                    over = sum_spans(t, npw, t);
                if (!over)
                    period = t;
            end
            if (wrapped)
                over = 1'b1;
            if (!cont_mode)
                running = 1'b0;

            want.period_ticks  = period[OUT_W-1:0];
            want.pulse_ticks   = pulse[OUT_W-1:0];
            want.status        = over;
            want.channel       = chan_sel;
            want.still_running = running;
            awaited_results.push_back(want);
            clear_counts();
            return 1'b1;
        endfunction

        task report(string msg);
            $display("ERROR @%0t: %s", $time, msg);
            failures++;
        endtask

        task compare_field(string name, wide_t got, wide_t want);
            if (got != want)
                report($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
        endtask

        task check_result(result_t got);
            result_t want;
            if (awaited_results.size() == 0)
            begin
                report($sformatf("unexpected result 0x%0h", got));
                return;
            end
            want = awaited_results.pop_front();
            compare_field("period_ticks", wide_t'(got.period_ticks),
                          wide_t'(want.period_ticks));
            compare_field("pulse_ticks", wide_t'(got.pulse_ticks),
                          wide_t'(want.pulse_ticks));
            compare_field("status", wide_t'(got.status), wide_t'(want.status));
            compare_field("channel", wide_t'(got.channel), wide_t'(want.channel));
            compare_field("still_running", wide_t'(got.still_running),
                          wide_t'(want.still_running));
        endtask

        task check_drained();
            if (awaited_results.size() != 0)
                report($sformatf("%0d results never arrived", awaited_results.size()));
        endtask
    endclass

endpackage

@@ dv/pulse_width_capture_extender_test.sv @@
`timescale 1ns / 100ps
// Top of the pulse width capture extender test: clock, reset, stimulus, result
// sink and cycle limit. Depends on pwce_pkg, pwce_in_if, pwce_out_if,
// pwce_capture_checker_pkg and the pulse_width_capture_extender RTL.
module pulse_width_capture_extender_test;
    import pwce_pkg::*;
    import pwce_capture_checker_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 1_000_000;
    localparam int          RANDOM_ITEMS    = 950;
    localparam int          SETTLE_CYCLES   = 4;
    localparam int          HOLD_OFF_CYCLES = 80;
    // overflows needed before count times the timer maximum fills the result
    localparam int          FILL_COUNT      = 32'h10001;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    bit          gaps_on;
    int          hold_off_request;
    int unsigned cycle_count;
    int          effective_items;

    capture_checker board = new();

    pwce_in_if  item_bus();
    pwce_out_if result_bus();

    pulse_width_capture_extender uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_bus),
        .result    (result_bus),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
        clk = 1'b0;

    always
        #5 clk = ~clk;

    // Hold every input at a known value before the first edge.
    initial
    begin
        rst_n                   = 1'b0;
        cfg_wr_en               = 1'b0;
        cfg_index               = '0;
        cfg_data                = '0;
        item_bus.valid          = 1'b0;
        item_bus.operation      = OP_START;
        item_bus.level_high     = 1'b0;
        item_bus.positive_width = '0;
        item_bus.negative_width = '0;
        result_bus.ready        = 1'b0;
        gaps_on                 = 1'b1;
        hold_off_request        = 0;
        cycle_count             = 0;
        effective_items         = 0;
    end

    // Idle length: mostly none, sometimes a few cycles, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 9);
        if (r < 6)
            return 0;
        if (r < 9)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Favour the extremes of a timer width, otherwise any value.
    function automatic logic [WIDTH_W-1:0] pick_width();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return WIDTH_W'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    // Result sink: drives ready at the falling edge. A hold-off request from
    // the stimulus is counted down here, independent of the sender.
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_request > 0)
            begin
                stall_left       = hold_off_request;
                hold_off_request = 0;
            end
            if (stall_left > 0)
            begin
                result_bus.ready <= 1'b0;
                stall_left--;
            end
            else if (gaps_on && $urandom_range(0, 3) == 0)
            begin
                result_bus.ready <= 1'b0;
                stall_left = pick_gap();
            end
            else
                result_bus.ready <= 1'b1;
        end
    end

    // Sample the result channel at the rising edge and hand each accepted
    // transaction to the scoreboard.
    always @(posedge clk)
    begin : result_monitor
        result_t got;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            got.period_ticks  = result_bus.period_ticks;
            got.pulse_ticks   = result_bus.pulse_ticks;
            got.status        = result_bus.status;
            got.channel       = result_bus.channel;
            got.still_running = result_bus.still_running;
            board.check_result(got);
        end
    end

    // Abort a run that hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Offer one transaction. Entered and left at a falling edge; valid stays
    // high into the next call so back-to-back transactions need no second
    // assignment in the same step.
    task automatic send_item(input logic [OP_W-1:0] op, input logic lvl,
                             input logic [WIDTH_W-1:0] ppw, input logic [WIDTH_W-1:0] npw);
        item_t it;
        int    gap;
        it.operation      = op;
        it.level_high     = lvl;
        it.positive_width = ppw;
        it.negative_width = npw;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_bus.valid          <= 1'b1;
        item_bus.operation      <= it.operation;
        item_bus.level_high     <= it.level_high;
        item_bus.positive_width <= it.positive_width;
        item_bus.negative_width <= it.negative_width;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
        if (board.note_item(it))
            effective_items++;
        @(negedge clk);
    endtask

    // Drop valid, wait for every awaited result, then let the pipeline settle
    // so that trailing transactions without a result are finished too.
    task automatic drain();
        item_bus.valid <= 1'b0;
        @(negedge clk);
        while (board.outstanding() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        board.write_reg(idx, data);
        @(negedge clk);
    endtask

    // Write all three registers; the unused upper data bit is randomised to
    // show that only the low bit counts for the one-bit registers.
    task automatic write_config(input logic [CHAN_W-1:0] chan, input logic inv,
                                input logic cont);
        write_reg(CFG_CHANNEL_SELECT, chan);
        write_reg(CFG_INVERTED_POLARITY, {1'($urandom_range(0, 1)), inv});
        write_reg(CFG_CONTINUOUS_MODE, {1'($urandom_range(0, 1)), cont});
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic overflow_burst(input logic lvl, input int count);
        repeat (count)
            send_item(OP_OVERFLOW, lvl, pick_width(), pick_width());
    endtask

    // Mostly well-formed captures with random content; the rest is noise that
    // also breaks captures up with stray stops and starts.
    task automatic random_sequence();
        int n;
        if ($urandom_range(0, 3) != 0)
        begin
            if (!board.capture_running())
                send_item(OP_START, 1'($urandom_range(0, 1)), pick_width(), pick_width());
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 60) : $urandom_range(0, 3);
            repeat (n)
                send_item(OP_OVERFLOW, 1'($urandom_range(0, 1)), pick_width(), pick_width());
            send_item(OP_READY, 1'($urandom_range(0, 1)), pick_width(), pick_width());
        end
        else
        begin
            repeat ($urandom_range(1, 3))
                send_item(OP_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                          pick_width(), pick_width());
        end
    endtask

    initial
    begin : stimulus
        int phase;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: highest channel, continuous capture.
        write_config(2'd3, 1'b0, 1'b1);
        // events while idle are dropped
        send_item(OP_READY, 1'b1, 16'h1234, 16'h5678);
        send_item(OP_OVERFLOW, 1'b1, 16'h0, 16'h0);
        send_item(OP_STOP, 1'b0, 16'h0, 16'h0);
        send_item(OP_START, 1'b0, 16'h0, 16'h0);
        send_item(OP_OVERFLOW, 1'b1, 16'hFFFF, 16'hFFFF);
        // a second start keeps the counts
        send_item(OP_START, 1'b1, 16'hFFFF, 16'hFFFF);
        send_item(OP_OVERFLOW, 1'b0, 16'h0, 16'h0);
        send_item(OP_READY, 1'b0, 16'hFFFF, 16'hFFFF);
        send_item(OP_READY, 1'b1, 16'h0, 16'h0);
        // counts survive a stop but widths ready is then dropped
        send_item(OP_OVERFLOW, 1'b1, 16'h0, 16'h0);
        send_item(OP_STOP, 1'b1, 16'hFFFF, 16'h0);
        send_item(OP_READY, 1'b0, 16'h0001, 16'h0001);
        send_item(OP_START, 1'b0, 16'h0, 16'h0);
        send_item(OP_READY, 1'b0, 16'h0001, 16'h8000);
        send_item(OP_STOP, 1'b0, 16'h0, 16'h0);
        drain();

        // One-shot, inverted polarity, lowest channel; a write to the unused
        // index must change nothing.
        write_reg(CFG_UNUSED, 2'd3);
        write_config(2'd0, 1'b1, 1'b0);
        send_item(OP_START, 1'b0, 16'h0, 16'h0);
        send_item(OP_OVERFLOW, 1'b0, 16'h0, 16'h0);
        send_item(OP_OVERFLOW, 1'b0, 16'h0, 16'h0);
        send_item(OP_READY, 1'b0, 16'hAAAA, 16'h5555);
        send_item(OP_READY, 1'b1, 16'h5555, 16'hAAAA);
        send_item(OP_START, 1'b0, 16'h0, 16'h0);
        drain();
        // register write during a capture is ignored
        write_reg(CFG_CHANNEL_SELECT, 2'd2);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
        send_item(OP_READY, 1'b0, 16'h0100, 16'h0200);
        drain();

        // Period overflow: fill the low count so that the period sum spills,
        // while the pulse (high side) still fits.
        gaps_on = 1'b0;
        write_config(2'd1, 1'b0, 1'b1);
        send_item(OP_START, 1'b0, 16'h0, 16'h0);
        overflow_burst(1'b0, FILL_COUNT);
        send_item(OP_READY, 1'b0, 16'hFFFF, 16'h0001);
        send_item(OP_STOP, 1'b0, 16'h0, 16'h0);
        drain();

        // Pulse overflow: same fill, but the low side is the pulse.
        write_config(2'd2, 1'b1, 1'b0);
        send_item(OP_START, 1'b0, 16'h0, 16'h0);
        overflow_burst(1'b0, FILL_COUNT);
        send_item(OP_READY, 1'b1, 16'h0, 16'h0001);
        drain();

        // Random phases, each under its own register setting.
        effective_items = 0;
        phase = 0;
        while (effective_items < RANDOM_ITEMS)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            if (phase == 0)
            begin
                // Back-pressure: hold the sink off for a long stretch while
                // the sender keeps offering, so the block fills and stalls.
                write_config(CHAN_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 1'b1);
                gaps_on = 1'b0;
                send_item(OP_START, 1'b0, 16'h0, 16'h0);
                hold_off_request = HOLD_OFF_CYCLES;
                repeat (24)
                    send_item(OP_READY, 1'($urandom_range(0, 1)), pick_width(), pick_width());
            end
            else
            begin
                if (phase == 1)
                    write_config(2'd0, 1'b0, 1'b0);
                else if (phase == 2)
                    write_config(2'd3, 1'b1, 1'b1);
                else
                    write_config(CHAN_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)));
                repeat ($urandom_range(10, 40))
                    random_sequence();
            end
            // stop the capture so the next setting is taken
            send_item(OP_STOP, 1'b0, pick_width(), pick_width());
            drain();
            phase++;
        end

        board.check_drained();
        if (board.failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
